// ===== design/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the perceptron train/classify block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // fixed field widths
    localparam int FEATURE_W = 16;
    localparam int WEIGHT_W  = 32;
    localparam int STEP_W    = 16;
    localparam int BIAS_W    = 32;
    localparam int LABEL_W   = 2;
    localparam int RESP_W    = 2;
    localparam int FIELD_W   = 48;
    localparam int ACC_W     = 64;
    localparam int PROD_W    = WEIGHT_W + FEATURE_W;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_VALUE = 1'd1;

    // reset values
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd256;

    // response codes
    localparam logic [RESP_W-1:0] RESP_NEG  = 2'b11;
    localparam logic [RESP_W-1:0] RESP_ZERO = 2'b00;
    localparam logic [RESP_W-1:0] RESP_POS  = 2'b01;

    // out-of-range label pattern, clamped to minus one
    localparam logic [LABEL_W-1:0] LABEL_BAD = 2'b10;
    localparam logic [LABEL_W-1:0] LABEL_NEG = 2'b11;

    // local field saturation limits
    localparam logic [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    // sequencer states
    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_FIELD,
        ST_EMIT,
        ST_UPDATE
    } state_t;

    // one cell of the ring: a weight and the buffered feature at its position
    typedef struct packed {
        logic [WEIGHT_W-1:0]  weight;
        logic [FEATURE_W-1:0] sample;
    } cell_data_t;

    // ring shift control
    typedef struct packed {
        logic shift_fwd;
        logic shift_bwd;
    } cell_ctrl_t;

endpackage

// ===== design/ptc_cell.sv =====
// ----------------------------------------------------------------------------
// ptc_cell
// One ring cell: holds a weight and its sample, shifts either way.
// ----------------------------------------------------------------------------
module ptc_cell
    import ptc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  cell_data_t fwd_in,
    input  cell_data_t bwd_in,
    output cell_data_t data_out
);

    logic [WEIGHT_W-1:0]  weight_reg;
    logic [FEATURE_W-1:0] sample_reg;
    cell_data_t           load_data;

    // pick the neighbor to take from
    always_comb begin
        if (ctrl.shift_fwd) begin
            load_data = fwd_in;
        end else begin
            load_data = bwd_in;
        end
    end

    // weight, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= '0;
        end else if (ctrl.shift_fwd || ctrl.shift_bwd) begin
            weight_reg <= load_data.weight;
        end
    end

    // buffered sample, no reset
    always_ff @(posedge aclk) begin
        if (ctrl.shift_fwd || ctrl.shift_bwd) begin
            sample_reg <= load_data.sample;
        end
    end

    assign data_out.weight = weight_reg;
    assign data_out.sample = sample_reg;

endmodule

// ===== design/ptc_update.sv =====
// ----------------------------------------------------------------------------
// ptc_update
// Learning-rule unit on the ring wrap: w + eta*err*x, saturated to 32 bits.
// ----------------------------------------------------------------------------
module ptc_update
    import ptc_pkg::*;
(
    input  logic [STEP_W-1:0] step_size,
    input  logic [2:0]        err,
    input  cell_data_t        cell_in,
    output cell_data_t        cell_out
);

    logic signed [32:0] prod;
    logic signed [34:0] prod_ext;
    logic signed [34:0] delta;
    logic signed [35:0] sum;

    // eta times feature, exact Q16.16
    assign prod     = $signed({1'b0, step_size}) * $signed(cell_in.sample);
    assign prod_ext = {{2{prod[32]}}, prod};

    // scale by the error, which lies in -2..2
    always_comb begin
        case (err)
            3'b010:  delta = prod_ext <<< 1;
            3'b001:  delta = prod_ext;
            3'b111:  delta = -prod_ext;
            3'b110:  delta = -(prod_ext <<< 1);
            default: delta = '0;
        endcase
    end

    assign sum = $signed({{4{cell_in.weight[WEIGHT_W-1]}}, cell_in.weight})
               + $signed({delta[34], delta});

    // saturate to signed 32 bits
    always_comb begin
        cell_out.sample = cell_in.sample;
        if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
            cell_out.weight = sum[31:0];
        end else if (sum[35]) begin
            cell_out.weight = {1'b1, {(WEIGHT_W-1){1'b0}}};
        end else begin
            cell_out.weight = {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
    end

endmodule

// ===== design/perceptron_train_classify.sv =====
// ----------------------------------------------------------------------------
// perceptron_train_classify
// Single perceptron with the classic learning rule, weights in a cell ring.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one signed Q8.8 feature per request; s_last_feature marks the
//   end of a sample, where s_operation (1 = train) and s_label are taken.
//   m_* returns one result per sample: the sign of the local field and the
//   field itself in Q24.24, saturated to 48 bits.
//   cfg_* writes step_size (index 0) and bias_value (index 1); always ready.
// Sequence:
//   non-final features are taken while accumulating. the final feature is
//   followed by product drain, bias add and sign/clip, then the weight ring
//   rotates back past the update unit one cell per cycle, once for each
//   buffered feature. no new feature is taken until the ring is back.
// Reset: weights clear to zero, step_size to 1.0, bias to zero, no result.
// Stall: a pending result waits in the output register; the block keeps
//   taking features of the next sample, and holds before emitting the next
//   result until the previous one is taken.
// ----------------------------------------------------------------------------
module perceptron_train_classify
    import ptc_pkg::*;
#(
    parameter int FEATURES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // feature requests
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [FEATURE_W-1:0] s_feature,
    input  logic [LABEL_W-1:0]   s_label,
    input  logic                 s_last_feature,
    // result requests
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [RESP_W-1:0]    m_response,
    output logic [FIELD_W-1:0]   m_local_field,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BIAS_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(FEATURES + 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [STEP_W-1:0]    step_size_reg;
    logic [BIAS_W-1:0]    bias_reg;
    logic                 train_reg;
    logic [LABEL_W-1:0]   label_reg;
    logic [RESP_W-1:0]    resp_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 prod_valid_reg;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     field_reg;
    logic                 m_valid_reg;
    logic [RESP_W-1:0]    m_response_reg;
    logic [FIELD_W-1:0]   m_local_field_reg;

    logic                 accept;
    logic                 has_room;
    logic                 emit_load;
    logic                 out_free;
    cell_ctrl_t           ring_ctrl;
    cell_data_t           cell_q [FEATURES];
    cell_data_t           wrap_fwd;
    cell_data_t           wrap_bwd;
    logic [2:0]           err;
    logic [RESP_W-1:0]    resp_calc;
    logic [FIELD_W-1:0]   field_clip;

    assign accept    = s_valid && s_ready;
    assign has_room  = (count_reg < CNT_W'(FEATURES));
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= STEP_RESET;
            bias_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_STEP_SIZE:  step_size_reg <= cfg_data[STEP_W-1:0];
                CFG_BIAS_VALUE: bias_reg      <= cfg_data;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM: begin
                if (accept && s_last_feature) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_FIELD;
            ST_FIELD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = (count_reg == '0) ? ST_ACCUM : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (count_reg == CNT_W'(1)) begin
                    state_next = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready             = 1'b0;
        emit_load           = 1'b0;
        ring_ctrl.shift_fwd = 1'b0;
        ring_ctrl.shift_bwd = 1'b0;
        unique case (state_reg)
            ST_ACCUM: begin
                s_ready             = 1'b1;
                ring_ctrl.shift_fwd = s_valid && has_room;
            end
            ST_DRAIN, ST_FIELD: begin
            end
            ST_EMIT:   emit_load           = out_free;
            ST_UPDATE: ring_ctrl.shift_bwd = 1'b1;
            default: begin
            end
        endcase
    end

    // state and feature count
    always_comb begin
        count_next = count_reg;
        if (ring_ctrl.shift_fwd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ring_ctrl.shift_bwd) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // sample-end controls taken with the final feature
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            train_reg <= 1'b0;
        end else if (accept && s_last_feature) begin
            train_reg <= s_operation;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_feature) begin
            label_reg <= (s_label == LABEL_BAD) ? LABEL_NEG : s_label;
        end
    end

    // multiply head weight by the incoming feature
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= ring_ctrl.shift_fwd;
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_ctrl.shift_fwd) begin
            prod_reg <= PROD_W'($signed(cell_q[0].weight) * $signed(s_feature));
        end
    end

    // dot product accumulator
    always_comb begin
        acc_next = acc_reg;
        if (state_reg == ST_FIELD) begin
            acc_next = '0;
        end else if (prod_valid_reg) begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // bias in Q24.24 added to the sum
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIELD) begin
            field_reg <= acc_reg
                + {{(ACC_W-BIAS_W-8){bias_reg[BIAS_W-1]}}, bias_reg, 8'd0};
        end
    end

    // sign and saturation of the field
    always_comb begin
        if (field_reg == '0) begin
            resp_calc = RESP_ZERO;
        end else if (field_reg[ACC_W-1]) begin
            resp_calc = RESP_NEG;
        end else begin
            resp_calc = RESP_POS;
        end
        if (field_reg[ACC_W-1:FIELD_W-1] == '0
            || field_reg[ACC_W-1:FIELD_W-1] == '1) begin
            field_clip = field_reg[FIELD_W-1:0];
        end else if (field_reg[ACC_W-1]) begin
            field_clip = FIELD_MIN;
        end else begin
            field_clip = FIELD_MAX;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_response_reg    <= resp_calc;
            m_local_field_reg <= field_clip;
            resp_reg          <= resp_calc;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_response    = m_response_reg;
    assign m_local_field = m_local_field_reg;

    // learning error, zero when only classifying
    always_comb begin
        if (train_reg) begin
            err = {label_reg[LABEL_W-1], label_reg} - {resp_reg[RESP_W-1], resp_reg};
        end else begin
            err = '0;
        end
    end

    // wrap paths of the ring
    assign wrap_fwd.weight = cell_q[0].weight;
    assign wrap_fwd.sample = s_feature;

    ptc_update u_update (
        .step_size (step_size_reg),
        .err       (err),
        .cell_in   (cell_q[FEATURES-1]),
        .cell_out  (wrap_bwd)
    );

    // ring of weight cells, head at cell zero
    for (genvar i = 0; i < FEATURES; i++) begin : g_cell
        cell_data_t fwd_src;
        cell_data_t bwd_src;
        if (i == FEATURES - 1) begin : g_tail
            assign fwd_src = wrap_fwd;
        end else begin : g_mid_f
            assign fwd_src = cell_q[i+1];
        end
        if (i == 0) begin : g_head
            assign bwd_src = wrap_bwd;
        end else begin : g_mid_b
            assign bwd_src = cell_q[i-1];
        end
        ptc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ring_ctrl),
            .fwd_in   (fwd_src),
            .bwd_in   (bwd_src),
            .data_out (cell_q[i])
        );
    end

endmodule

// ===== design/ptc_checker.sv =====
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the perceptron block, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker
    import ptc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_last_feature,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [RESP_W-1:0]    m_response,
    input logic [FIELD_W-1:0]   m_local_field
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_response)
                               && $stable(m_local_field))
        else $error("stalled result changed");

    // response agrees with the sign of the field
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_local_field == '0) && (m_response == RESP_ZERO))
                 || (m_local_field[FIELD_W-1] && (m_response == RESP_NEG))
                 || (!m_local_field[FIELD_W-1] && (m_local_field != '0)
                     && (m_response == RESP_POS)))
        else $error("response does not match field sign");

    // the end of a sample closes the input while the field is formed
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_feature |=> !s_ready)
        else $error("input still open after final feature");

endmodule

bind perceptron_train_classify ptc_checker u_ptc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_last_feature (s_last_feature),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_response     (m_response),
    .m_local_field  (m_local_field)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the perceptron train/classify block. A directed
// table covers reset behavior, field and weight saturation, the clamped label
// pattern, short and overlong samples; random phases under several learning
// rates and biases follow. Results are checked vs. local predictor or table.
// ----------------------------------------------------------------------------
module tb_top;
    import ptc_pkg::*;

    localparam int FEATURES        = 8;
    localparam int DRAIN_CYCLES    = 4 * FEATURES + 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 80;

    // request codes
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_TRAIN    = 1'b1;
    localparam logic [LABEL_W-1:0] LABEL_ZERO = 2'b00;
    localparam logic [LABEL_W-1:0] LABEL_POS  = 2'b01;

    // saturation limits at accumulator width
    localparam logic signed [63:0] FIELD_HI  = {16'h0000, FIELD_MAX};
    localparam logic signed [63:0] FIELD_LO  = {16'hFFFF, FIELD_MIN};
    localparam logic signed [63:0] WEIGHT_HI = 64'sd2147483647;
    localparam logic signed [63:0] WEIGHT_LO = -64'sd2147483648;

    typedef enum logic {ROW_FEATURE, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        logic [RESP_W-1:0]  response;
        logic [FIELD_W-1:0] local_field;
    } result_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [BIAS_W-1:0]     cfg_data;
        logic                  op;
        logic [FEATURE_W-1:0]  feature;
        logic [LABEL_W-1:0]    label;
        logic                  last;
        logic                  typed;
        logic [RESP_W-1:0]     exp_resp;
        logic [FIELD_W-1:0]    exp_field;
    } stim_row_t;

    localparam int DIR_ROWS = 28;

    // directed stimulus, typed results only where obvious
    stim_row_t dir_table [DIR_ROWS] = '{
        // zero weights after reset give a zero field
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h7FFF, LABEL_ZERO, 1'b1,
          1'b1, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_TRAIN, 16'h8000, LABEL_POS, 1'b1,
          1'b1, RESP_ZERO, 48'd0},
        // largest step, most negative bias
        '{ROW_CONFIG, CFG_STEP_SIZE, 32'h0000_FFFF, OP_CLASSIFY, 16'h0000, LABEL_ZERO,
          1'b0, 1'b0, RESP_ZERO, 48'd0},
        '{ROW_CONFIG, CFG_BIAS_VALUE, 32'h8000_0000, OP_CLASSIFY, 16'h0000, LABEL_ZERO,
          1'b0, 1'b0, RESP_ZERO, 48'd0},
        // train drives three weights into saturation; early op/label ignored
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h7FFF, LABEL_NEG, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_TRAIN, 16'h7FFF, LABEL_BAD, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_TRAIN, 16'h7FFF, LABEL_POS, 1'b1,
          1'b0, RESP_ZERO, 48'd0},
        // positive field overflow
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h7FFF, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h7FFF, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h7FFF, LABEL_ZERO, 1'b1,
          1'b1, RESP_POS, FIELD_MAX},
        // negative field overflow
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h8000, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h8000, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h8000, LABEL_ZERO, 1'b1,
          1'b1, RESP_NEG, FIELD_MIN},
        // back to unit step and zero bias
        '{ROW_CONFIG, CFG_STEP_SIZE, 32'd256, OP_CLASSIFY, 16'h0000, LABEL_ZERO,
          1'b0, 1'b0, RESP_ZERO, 48'd0},
        '{ROW_CONFIG, CFG_BIAS_VALUE, 32'd0, OP_CLASSIFY, 16'h0000, LABEL_ZERO,
          1'b0, 1'b0, RESP_ZERO, 48'd0},
        // out-of-range label pattern trains as minus one
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_TRAIN, 16'h0100, LABEL_BAD, 1'b1,
          1'b0, RESP_ZERO, 48'd0},
        // short sample
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_TRAIN, 16'h0001, LABEL_POS, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h8000, LABEL_NEG, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_TRAIN, 16'h0000, LABEL_ZERO, 1'b1,
          1'b0, RESP_ZERO, 48'd0},
        // overlong sample, the ninth feature is dropped
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h1234, LABEL_POS, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_TRAIN, 16'h8001, LABEL_BAD, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h7FFE, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h0000, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'hFFFF, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h0080, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'h4000, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_CLASSIFY, 16'hC000, LABEL_ZERO, 1'b0,
          1'b0, RESP_ZERO, 48'd0},
        '{ROW_FEATURE, CFG_STEP_SIZE, 32'd0, OP_TRAIN, 16'h5A5A, LABEL_NEG, 1'b1,
          1'b0, RESP_ZERO, 48'd0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_operation;
    logic [FEATURE_W-1:0] s_feature;
    logic [LABEL_W-1:0]   s_label;
    logic                 s_last_feature;
    logic                 m_valid;
    logic                 m_ready;
    logic [RESP_W-1:0]    m_response;
    logic [FIELD_W-1:0]   m_local_field;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BIAS_W-1:0]    cfg_data;

    // predictor state
    logic signed [WEIGHT_W-1:0]  weights    [FEATURES];
    logic        [FEATURE_W-1:0] sample_buf [FEATURES];
    logic signed [63:0]          field_acc;
    int                          feat_count;
    logic        [STEP_W-1:0]    step_reg;
    logic signed [BIAS_W-1:0]    bias_reg;

    result_t pending_results [$];
    int      error_count;
    int      cycle_count;
    int      items_sent;
    int      results_checked;
    int      cfg_writes;
    int      field_clips;
    int      weight_sats;
    bit      steady_mode;

    perceptron_train_classify #(
        .FEATURES(FEATURES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_feature     (s_feature),
        .s_label       (s_label),
        .s_last_feature(s_last_feature),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_response    (m_response),
        .m_local_field (m_local_field),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (steady_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // advance the perceptron by one feature; returns 1 when a result is due
    function automatic bit advance_perceptron(input logic op, input logic [FEATURE_W-1:0] feat,
                                              input logic [LABEL_W-1:0] lab, input logic last,
                                              output result_t res);
        logic signed [63:0] wide_w;
        logic signed [63:0] wide_x;
        logic signed [63:0] wide_s;
        logic signed [63:0] field;
        logic signed [63:0] err;
        logic signed [63:0] lab_s;
        logic signed [63:0] resp_s;
        logic signed [63:0] sum;
        logic [RESP_W-1:0]  resp;
        if (feat_count < FEATURES) begin
            sample_buf[feat_count] = feat;
            wide_w = weights[feat_count];
            wide_x = $signed(feat);
            field_acc = field_acc + wide_w * wide_x;
            feat_count++;
        end
        if (!last) return 1'b0;

        // bias moves from Q16.16 to Q24.24
        wide_w = bias_reg;
        field = field_acc + wide_w * 64'sd256;
        if (field == 0) resp = RESP_ZERO;
        else if (field < 0) resp = RESP_NEG;
        else resp = RESP_POS;
        res.response = resp;
        if (field > FIELD_HI) begin
            res.local_field = FIELD_MAX;
            field_clips++;
        end else if (field < FIELD_LO) begin
            res.local_field = FIELD_MIN;
            field_clips++;
        end else begin
            res.local_field = field[FIELD_W-1:0];
        end

        // learning rule over the features received in this sample
        if (op == OP_TRAIN) begin
            lab_s = $signed(lab);
            if (lab == LABEL_BAD) lab_s = -64'sd1;
            resp_s = $signed(resp);
            err = lab_s - resp_s;
            wide_s = {48'd0, step_reg};
            for (int i = 0; i < feat_count; i++) begin
                wide_x = $signed(sample_buf[i]);
                wide_w = weights[i];
                sum = wide_w + wide_s * wide_x * err;
                if (sum > WEIGHT_HI) begin
                    sum = WEIGHT_HI;
                    weight_sats++;
                end else if (sum < WEIGHT_LO) begin
                    sum = WEIGHT_LO;
                    weight_sats++;
                end
                weights[i] = sum[WEIGHT_W-1:0];
            end
        end
        field_acc = '0;
        feat_count = 0;
        return 1'b1;
    endfunction

    // one feature request, entered and left at a falling edge
    task automatic send_feature(input logic op, input logic [FEATURE_W-1:0] feat,
                                input logic [LABEL_W-1:0] lab, input logic last,
                                input logic typed, input result_t typed_res);
        result_t res;
        int      gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_operation    = op;
        s_feature      = feat;
        s_label        = lab;
        s_last_feature = last;
        s_valid        = 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (advance_perceptron(op, feat, lab, last, res))
            pending_results.push_back(typed ? typed_res : res);
        items_sent++;
        @(negedge aclk);
    endtask

    // register write, only once the block has gone idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [BIAS_W-1:0] data);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_STEP_SIZE) step_reg = data[STEP_W-1:0];
        else bias_reg = data;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // result side back-pressure
    initial begin : result_ready_gen
        int burst;
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            burst = $urandom_range(1, 30);
            m_ready = 1'b1;
            repeat (burst) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result request with no expected result");
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (m_response !== exp_res.response) begin
                    $error("response mismatch: expected %0d, actual %0d",
                           $signed(exp_res.response), $signed(m_response));
                    error_count++;
                end
                if (m_local_field !== exp_res.local_field) begin
                    $error("local_field mismatch: expected %0d, actual %0d",
                           $signed(exp_res.local_field), $signed(m_local_field));
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        result_t              no_res;
        result_t              row_res;
        int                   r;
        int                   len;
        int                   phase_items;
        logic                 op;
        logic [LABEL_W-1:0]   lab;
        logic [FEATURE_W-1:0] feat;
        logic [BIAS_W-1:0]    step_word;
        logic [BIAS_W-1:0]    bias_word;

        no_res          = '0;
        items_sent      = 0;
        cfg_writes      = 0;
        field_clips     = 0;
        weight_sats     = 0;
        steady_mode     = 1'b0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_operation     = 1'b0;
        s_feature       = '0;
        s_label         = '0;
        s_last_feature  = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;

        // predictor reset state
        foreach (weights[i]) begin
            weights[i]    = '0;
            sample_buf[i] = '0;
        end
        field_acc  = '0;
        feat_count = 0;
        step_reg   = STEP_RESET;
        bias_reg   = '0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (dir_table[n]) begin
            if (dir_table[n].kind == ROW_CONFIG) begin
                write_register(dir_table[n].cfg_index, dir_table[n].cfg_data);
            end else begin
                row_res.response    = dir_table[n].exp_resp;
                row_res.local_field = dir_table[n].exp_field;
                send_feature(dir_table[n].op, dir_table[n].feature, dir_table[n].label,
                             dir_table[n].last, dir_table[n].typed, row_res);
            end
        end

        // random phases, each under its own step and bias
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    step_word = 32'h0000_FFFF;
                    bias_word = 32'h8000_0000;
                end
                1: begin
                    step_word = 32'd0;
                    bias_word = 32'h7FFF_FFFF;
                end
                3: begin
                    step_word = {16'd0, STEP_RESET};
                    bias_word = 32'd0;
                end
                4: begin
                    step_word = 32'($urandom_range(0, 1023));
                    bias_word = 32'($urandom_range(0, 1 << 20)) - 32'h0008_0000;
                end
                default: begin
                    step_word = $urandom;
                    bias_word = $urandom;
                end
            endcase
            write_register(CFG_STEP_SIZE, step_word);
            write_register(CFG_BIAS_VALUE, bias_word);
            steady_mode = (ph == 2);

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                // sample length: mostly in range, some full, some overlong
                r = $urandom_range(0, 99);
                if (r < 70) len = $urandom_range(1, FEATURES);
                else if (r < 85) len = FEATURES;
                else len = $urandom_range(FEATURES + 1, FEATURES + 4);
                op  = 1'($urandom_range(0, 1));
                lab = 2'($urandom_range(0, 3));
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 15) feat = 16'h7FFF;
                    else if (r < 30) feat = 16'h8000;
                    else if (r < 40) feat = 16'h0000;
                    else if (r < 70) feat = 16'($urandom_range(0, 1023)) - 16'd512;
                    else feat = 16'($urandom);
                    if (k == len - 1)
                        send_feature(op, feat, lab, 1'b1, 1'b0, no_res);
                    else
                        send_feature(1'($urandom_range(0, 1)), feat, 2'($urandom_range(0, 3)),
                                     1'b0, 1'b0, no_res);
                end
                phase_items += len;
            end
        end
        s_valid = 1'b0;
        steady_mode = 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d feature requests, %0d results checked, %0d register writes",
                 items_sent, results_checked, cfg_writes);
        $display("Saturation seen: %0d local fields, %0d weight updates",
                 field_clips, weight_sats);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ptc_pkg.sv
design/ptc_cell.sv
design/ptc_update.sv
design/perceptron_train_classify.sv
design/ptc_checker.sv
verif/tb_top.sv
